@@ rtl/ltn_pkg.sv @@
// Shared types, constants and a lookup function for the Latin text normalizer.
package ltn_pkg;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_FOLD = 2'd1,
      MODE_SKIP = 2'd2
   } mode_type;

   localparam logic [7:0] LEAD_FOLD = 8'hC3;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_A     = 7'h61;
   localparam logic [6:0] CH_C     = 7'h63;
   localparam logic [6:0] CH_D     = 7'h64;
   localparam logic [6:0] CH_E     = 7'h65;
   localparam logic [6:0] CH_I     = 7'h69;
   localparam logic [6:0] CH_N     = 7'h6E;
   localparam logic [6:0] CH_O     = 7'h6F;
   localparam logic [6:0] CH_P     = 7'h70;
   localparam logic [6:0] CH_S     = 7'h73;
   localparam logic [6:0] CH_U     = 7'h75;
   localparam logic [6:0] CH_X     = 7'h78;
   localparam logic [6:0] CH_Y     = 7'h79;

   typedef struct packed {
      logic       emit;
      logic [6:0] out_byte;
      mode_type   next_mode;
   } step_type;

   // Fold of the second byte of a 0xC3 sequence (Latin-1 0xC0..0xFF).
   function automatic logic [6:0] fold_char(input logic [5:0] idx);
      logic [6:0] ch;
      case (idx) inside
         [6'd0:6'd5], [6'd32:6'd37]:                   ch = CH_A;
         6'd6, [6'd8:6'd11], 6'd38, [6'd40:6'd43]:    ch = CH_E;
         6'd7, 6'd39:                                  ch = CH_C;
         [6'd12:6'd15], [6'd44:6'd47]:                 ch = CH_I;
         6'd16:                                        ch = CH_D;
         6'd17, 6'd49:                                 ch = CH_N;
         [6'd18:6'd22], [6'd48:6'd48], [6'd50:6'd54]: ch = CH_O;
         6'd23:                                        ch = CH_X;
         6'd24, 6'd56:                                 ch = CH_ZERO;
         [6'd25:6'd28], [6'd57:6'd60]:                 ch = CH_U;
         6'd29, 6'd61, 6'd63:                          ch = CH_Y;
         6'd30, 6'd62:                                 ch = CH_P;
         6'd31:                                        ch = CH_S;
         default:                                      ch = CH_SPACE;
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/latin_text_normalizer.sv @@
// Top level of the Latin text normalizer: request register, decode, response register.
// Takes one byte of UTF-8 text per request and returns zero or one normalized
// 7-bit character (lowercase letter, digit or space). A request is registered,
// decoded in the following cycle and its character, if any, lands in the
// response register. The block sustains one request per cycle, including
// while a response waits to be taken as long as the waiting request emits
// nothing. A 0xC3 lead folds the next byte through the Latin-1 table; any
// other high byte drops the byte after it. req_start_of_text clears a pending
// lead before its byte is handled.
module latin_text_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_byte
);
   import ltn_pkg::*;

   logic       req_valid_ff;
   logic [7:0] byte_ff;
   logic       sof_ff;
   mode_type   mode_ff;
   logic       rsp_valid_ff;
   logic [6:0] rsp_byte_ff;
   step_type   step;
   logic       advance;

   ltn_step u_step (
      .in_byte       (byte_ff),
      .start_of_text (sof_ff),
      .mode          (mode_ff),
      .step          (step)
   );

   // the decoded request moves on unless it needs a response slot that is held
   assign advance   = req_valid_ff && (!step.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         mode_ff      <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            mode_ff <= step.next_mode;
         end
         if (advance && step.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_in_byte;
         sof_ff  <= req_start_of_text;
      end
      if (advance && step.emit) begin
         rsp_byte_ff <= step.out_byte;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule

@@ rtl/ltn_step.sv @@
// Per-byte decode: pending-mode handling, Latin-1 fold and ASCII classification.
module ltn_step (
   input  logic [7:0]         in_byte,
   input  logic               start_of_text,
   input  ltn_pkg::mode_type  mode,
   output ltn_pkg::step_type  step
);
   import ltn_pkg::*;

   mode_type   eff_mode;
   logic [6:0] c;
   logic       drop;
   logic       to_space;
   logic       upper;

   assign eff_mode = start_of_text ? MODE_NONE : mode;
   assign c        = in_byte[6:0];

   assign drop = (c <= 7'd8) || (c >= 7'd11 && c <= 7'd31) || (c >= 7'd126) ||
                 (c == 7'd39) || (c == 7'd94);
   assign to_space = (c <= 7'd10) || (c >= 7'd32 && c <= 7'd47) ||
                     (c >= 7'd58 && c <= 7'd64) || (c >= 7'd91 && c <= 7'd96) ||
                     (c >= 7'd123 && c <= 7'd125);
   assign upper = (c >= 7'd65) && (c <= 7'd90);

   always_comb begin
      step.emit      = 1'b0;
      step.out_byte  = CH_SPACE;
      step.next_mode = MODE_NONE;
      case (eff_mode)
         MODE_FOLD: begin
            // bad continuation byte is swallowed
            if (in_byte[7:6] == 2'b10) begin
               step.emit     = 1'b1;
               step.out_byte = fold_char(in_byte[5:0]);
            end
         end
         MODE_SKIP: begin
            step.emit = 1'b0;
         end
         default: begin
            if (in_byte[7]) begin
               step.next_mode = (in_byte == LEAD_FOLD) ? MODE_FOLD : MODE_SKIP;
            end else if (!drop) begin
               step.emit = 1'b1;
               if (to_space) begin
                  step.out_byte = CH_SPACE;
               end else if (upper) begin
                  step.out_byte = c + 7'd32;
               end else begin
                  step.out_byte = c;
               end
            end
         end
      endcase
   end

endmodule
